>>> design/tcw_pkg.sv
// Shared constants and default sizes for the text console writer.
`default_nettype none
package tcw_pkg;

   // Default screen geometry and tab spacing.
   localparam int DEF_COLUMNS  = 80;
   localparam int DEF_ROWS     = 25;
   localparam int DEF_TAB_STOP = 4;

   // A cell holds the character in the low byte and the colour in the high byte.
   localparam int CELL_W = 16;

   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;

   localparam logic [7:0] RESET_COLOUR = 8'h0F;

endpackage
`default_nettype wire

>>> design/tcw_cell_mem.sv
// Screen cell store: one write port and one read port with registered read data.
`default_nettype none
module tcw_cell_mem
   import tcw_pkg::*;
#(
   parameter int DEPTH = DEF_COLUMNS * DEF_ROWS,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [CELL_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] cells [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= cells[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> design/tcw_offset_unit.sv
// Shared offset unit: registers row * COLUMNS + column for addressing and reporting.
`default_nettype none
module tcw_offset_unit
   import tcw_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS,
   localparam int CW = $clog2(COLUMNS + 1),
   localparam int RW = $clog2(ROWS),
   localparam int OW = $clog2(COLUMNS * ROWS + 1)
) (
   input  wire logic          clock,
   input  wire logic [RW-1:0] row_sel,
   input  wire logic [CW-1:0] col_sel,
   output logic      [OW-1:0] offset
);

   logic [OW-1:0] offset_ff;
   logic [OW-1:0] offset_in;

   assign offset_in = OW'(row_sel) * OW'(COLUMNS) + OW'(col_sel);

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
   end

   assign offset = offset_ff;

endmodule
`default_nettype wire

>>> design/text_console_writer.sv
// Text console writer top level: sequencer, cursor, colour register and result stage.
//
//   Channel   Ports                       Direction  Moves
//   req       req_valid / req_ready       in         one action per transaction
//   rsp       rsp_valid / rsp_ready       out        cursor and read cell per transaction
//   csr       csr_wr_en / csr_wr_data     in         text colour, no wait
//
// A read fetches the target cell from the cell store, and an out-of-range read returns a
// zero cell. A tab first reduces the column modulo TAB_STOP by repeated subtraction, then
// writes spaces one at a time. A scroll walks the cell store once and blanks the last row;
// a clear blanks every cell. After reset a clearing pass keeps req_ready low.
// A new transaction is taken while the last result still waits.
`default_nettype none
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS  = DEF_COLUMNS,
   parameter int ROWS     = DEF_ROWS,
   parameter int TAB_STOP = DEF_TAB_STOP
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [6:0]  req_target_column,
   input  wire logic [4:0]  req_target_row,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [6:0]       rsp_cursor_column,
   output logic [4:0]       rsp_cursor_row,
   output logic [10:0]      rsp_cursor_offset,
   output logic [7:0]       rsp_cell_char,
   output logic [7:0]       rsp_cell_attr,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int CW    = $clog2(COLUMNS + 1);
   localparam int RW    = $clog2(ROWS);
   localparam int OW    = $clog2(CELLS + 1);
   localparam int AW    = $clog2(CELLS);
   localparam int SW    = $clog2(TAB_STOP + 1);

   typedef enum logic [1:0] {
      ACT_PUT   = 2'd0,
      ACT_SET   = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_PUT,
      S_NL,
      S_SCROLL,
      S_FILL,
      S_SETTLE,
      S_TABMOD,
      S_TABSP,
      S_BSW,
      S_RD1,
      S_RD2,
      S_FIN,
      S_OUT
   } state_type;

   state_type        state_ff, state_in;
   state_type        ret_ff, ret_in;
   action_type       action_ff, action_in;
   logic [CW-1:0]    cur_col_ff, cur_col_in;
   logic [RW-1:0]    cur_row_ff, cur_row_in;
   logic [7:0]       colour_ff, colour_in;
   logic [7:0]       ch_ff, ch_in;
   logic [6:0]       tgt_col_ff, tgt_col_in;
   logic [4:0]       tgt_row_ff, tgt_row_in;
   logic [OW-1:0]    ptr_ff, ptr_in;
   logic [CW-1:0]    rem_ff, rem_in;
   logic [SW-1:0]    spaces_ff, spaces_in;
   logic [7:0]       cell_char_ff, cell_char_in;
   logic [7:0]       cell_attr_ff, cell_attr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [6:0]       rsp_col_ff, rsp_col_in;
   logic [4:0]       rsp_row_ff, rsp_row_in;
   logic [10:0]      rsp_off_ff, rsp_off_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic [7:0]       rsp_attr_ff, rsp_attr_in;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;
   logic [CELL_W-1:0] mem_rdata;

   logic [RW-1:0]     unit_row;
   logic [CW-1:0]     unit_col;
   logic [OW-1:0]     unit_off;

   logic              tgt_col_ok;
   logic              tgt_row_ok;
   logic              rsp_load;

   assign tgt_col_ok = 32'(tgt_col_ff) < COLUMNS;
   assign tgt_row_ok = 32'(tgt_row_ff) < ROWS;

   tcw_cell_mem #(
      .DEPTH(CELLS)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (mem_re),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   tcw_offset_unit #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_offset (
      .clock  (clock),
      .row_sel(unit_row),
      .col_sel(unit_col),
      .offset (unit_off)
   );

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      action_in    = action_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      colour_in    = colour_ff;
      ch_in        = ch_ff;
      tgt_col_in   = tgt_col_ff;
      tgt_row_in   = tgt_row_ff;
      ptr_in       = ptr_ff;
      rem_in       = rem_ff;
      spaces_in    = spaces_ff;
      cell_char_in = cell_char_ff;
      cell_attr_in = cell_attr_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      rsp_load     = 1'b0;

      mem_we    = 1'b0;
      mem_waddr = unit_off[AW-1:0];
      mem_wdata = {colour_ff, CHAR_SPACE};
      mem_re    = 1'b0;
      mem_raddr = unit_off[AW-1:0];

      // The offset unit follows the cursor unless a read needs the target cell.
      unit_row = cur_row_ff;
      unit_col = cur_col_ff;

      if (csr_wr_en) begin
         colour_in = csr_wr_data;
      end

      case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[AW-1:0];
            mem_wdata = {RESET_COLOUR, CHAR_SPACE};
            ptr_in    = ptr_ff + OW'(1);
            if (ptr_ff == OW'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               action_in    = action_type'(req_action);
               ch_in        = req_char_code;
               tgt_col_in   = req_target_column;
               tgt_row_in   = req_target_row;
               cell_char_in = 8'd0;
               cell_attr_in = 8'd0;
               state_in     = (action_type'(req_action) == ACT_PUT) ? S_PUT : S_EXEC;
            end
         end
         S_EXEC: begin
            case (action_ff)
               ACT_SET: begin
                  cur_col_in = tgt_col_ok ? CW'(tgt_col_ff) : CW'(COLUMNS - 1);
                  cur_row_in = tgt_row_ok ? RW'(tgt_row_ff) : RW'(ROWS - 1);
                  state_in   = S_FIN;
               end
               ACT_CLEAR: begin
                  ptr_in   = '0;
                  ret_in   = S_FIN;
                  state_in = S_FILL;
               end
               ACT_READ: begin
                  if (tgt_col_ok && tgt_row_ok) begin
                     unit_row = RW'(tgt_row_ff);
                     unit_col = CW'(tgt_col_ff);
                     state_in = S_RD1;
                  end else begin
                     state_in = S_FIN;
                  end
               end
               default: begin
                  state_in = S_PUT;
               end
            endcase
         end
         S_PUT: begin
            if (cur_col_ff >= CW'(COLUMNS)) begin
               // A full line wraps before the byte is handled.
               ret_in   = S_PUT;
               state_in = S_NL;
            end else begin
               case (ch_ff)
                  CHAR_NEWLINE: begin
                     ret_in   = S_FIN;
                     state_in = S_NL;
                  end
                  CHAR_TAB: begin
                     rem_in   = cur_col_ff;
                     state_in = S_TABMOD;
                  end
                  CHAR_RETURN: begin
                     cur_col_in = '0;
                     state_in   = S_FIN;
                  end
                  CHAR_BACKSPACE: begin
                     if (cur_col_ff != '0) begin
                        cur_col_in = cur_col_ff - CW'(1);
                        ret_in     = S_BSW;
                        state_in   = S_SETTLE;
                     end else begin
                        state_in = S_FIN;
                     end
                  end
                  default: begin
                     mem_we     = 1'b1;
                     mem_wdata  = {colour_ff, ch_ff};
                     cur_col_in = cur_col_ff + CW'(1);
                     state_in   = S_FIN;
                  end
               endcase
            end
         end
         S_NL: begin
            cur_col_in = '0;
            if (cur_row_ff == RW'(ROWS - 1)) begin
               ptr_in   = OW'(COLUMNS);
               state_in = S_SCROLL;
            end else begin
               cur_row_in = cur_row_ff + RW'(1);
               state_in   = S_SETTLE;
            end
         end
         S_SCROLL: begin
            // Read one cell ahead while the cell read last cycle moves up one row.
            mem_re    = ptr_ff != OW'(CELLS);
            mem_raddr = ptr_ff[AW-1:0];
            if (ptr_ff > OW'(COLUMNS)) begin
               mem_we    = 1'b1;
               mem_waddr = AW'(ptr_ff - OW'(COLUMNS) - OW'(1));
               mem_wdata = mem_rdata;
            end
            if (ptr_ff == OW'(CELLS)) begin
               ptr_in   = OW'((ROWS - 1) * COLUMNS);
               state_in = S_FILL;
            end else begin
               ptr_in = ptr_ff + OW'(1);
            end
         end
         S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[AW-1:0];
            ptr_in    = ptr_ff + OW'(1);
            if (ptr_ff == OW'(CELLS - 1)) begin
               state_in = S_SETTLE;
            end
         end
         S_SETTLE: begin
            // This state lets the registered offset unit catch up with the new cursor.
            state_in = ret_ff;
         end
         S_TABMOD: begin
            if (32'(rem_ff) >= TAB_STOP) begin
               rem_in = rem_ff - CW'(TAB_STOP);
            end else begin
               spaces_in = SW'(TAB_STOP) - SW'(rem_ff);
               state_in  = S_TABSP;
            end
         end
         S_TABSP: begin
            if (cur_col_ff >= CW'(COLUMNS)) begin
               ret_in   = S_TABSP;
               state_in = S_NL;
            end else begin
               mem_we     = 1'b1;
               cur_col_in = cur_col_ff + CW'(1);
               spaces_in  = spaces_ff - SW'(1);
               if (spaces_ff == SW'(1)) begin
                  state_in = S_FIN;
               end else begin
                  ret_in   = S_TABSP;
                  state_in = S_SETTLE;
               end
            end
         end
         S_BSW: begin
            mem_we   = 1'b1;
            state_in = S_FIN;
         end
         S_RD1: begin
            mem_re   = 1'b1;
            state_in = S_RD2;
         end
         S_RD2: begin
            cell_char_in = mem_rdata[7:0];
            cell_attr_in = mem_rdata[15:8];
            state_in     = S_FIN;
         end
         S_FIN: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load    = 1'b1;
               rsp_col_in  = 7'(cur_col_ff);
               rsp_row_in  = 5'(cur_row_ff);
               rsp_off_in  = 11'(unit_off);
               rsp_char_in = cell_char_ff;
               rsp_attr_in = cell_attr_ff;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         ret_ff       <= S_FIN;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         colour_ff    <= RESET_COLOUR;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         colour_ff    <= colour_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff    <= action_in;
      ch_ff        <= ch_in;
      tgt_col_ff   <= tgt_col_in;
      tgt_row_ff   <= tgt_row_in;
      rem_ff       <= rem_in;
      spaces_ff    <= spaces_in;
      cell_char_ff <= cell_char_in;
      cell_attr_ff <= cell_attr_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_attr_ff  <= rsp_attr_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_column = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_offset = rsp_off_ff;
   assign rsp_cell_char     = rsp_char_ff;
   assign rsp_cell_attr     = rsp_attr_ff;

endmodule
`default_nettype wire
